// File: src/hfmt_pkg.sv
// Shared types, constants and helpers for the hex float text formatter.
// Used by every module of the block; depends on nothing.

package hfmt_pkg;

   // Item layout
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 8;
   localparam int FRAC_NIBS  = 15;
   localparam int EXP_W      = 16;
   localparam int AEXP_W     = 15;
   localparam int PREC_W     = 6;
   localparam int DIGITS     = 5;
   localparam int DIG_IDX_W  = 3;
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = $clog2(QDEPTH);

   // Precision limits and format constants
   localparam logic [PREC_W-1:0] PREC_MAX    = 6'd48;
   localparam logic [3:0]        NN_DOUBLE   = 4'd13;
   localparam logic [3:0]        NN_EXTENDED = 4'd15;
   localparam logic signed [EXP_W-1:0] DBL_BIAS       = 16'sd1023;
   localparam logic signed [EXP_W-1:0] DBL_DENORM_EXP = -16'sd1022;
   localparam logic signed [EXP_W-1:0] EXT_EXP_ADJ    = 16'sd16386;
   localparam logic signed [EXP_W-1:0] RENORM_STEP    = 16'sd4;

   // Reciprocal of ten, valid for exponent magnitudes well past 16389
   localparam logic [31:0] RECIP_TEN  = 32'd52429;
   localparam int          RECIP_SHFT = 19;

   // ASCII codes
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_P_LO  = 8'h70;
   localparam logic [7:0] CH_P_UP  = 8'h50;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_A_UP  = 8'h41;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;

   // Fraction nibbles, index 0 is the most significant
   typedef logic [0:FRAC_NIBS-1][3:0] hfmt_frac_type;

   // One formatted value waiting for the character sequencer
   typedef struct packed {
      logic [3:0]                 lead;
      hfmt_frac_type              frac;
      logic [PREC_W-1:0]          n_frac;
      logic                       dot;
      logic                       upper;
      logic                       neg;
      logic [DIG_IDX_W-1:0]       n_dig;
      logic [DIGITS-1:0][3:0]     dig;
   } hfmt_entry_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_ROUND,
      F_EXP,
      F_DIG,
      F_PUSH
   } hfmt_front_state_type;

   typedef enum logic [2:0] {
      B_ZERO,
      B_X,
      B_LEAD,
      B_DOT,
      B_FRAC,
      B_PCHAR,
      B_SIGN,
      B_DIGIT
   } hfmt_back_state_type;

   // Hex digit to ASCII
   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      base = upper ? CH_A_UP : CH_A_LO;
      if (nib < 4'd10) begin
         return CH_ZERO + {4'b0, nib};
      end
      return base + {4'b0, nib} - 8'd10;
   endfunction

endpackage

// File: src/hfmt_front.sv
// Front end: accepts a value, decodes the format, rounds the fraction and
// converts the exponent to decimal digits. Depends on hfmt_pkg.

module hfmt_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [87:0]              req_tdata,
   input  logic                     req_tuser,
   output logic                     push_valid,
   input  logic                     push_ready,
   output hfmt_pkg::hfmt_entry_type push_entry
);
   import hfmt_pkg::*;

   hfmt_front_state_type state_ff, state_in;

   logic [3:0]                 lead_ff, lead_in;
   hfmt_frac_type              frac_ff, frac_in;
   logic signed [EXP_W-1:0]    exp_ff, exp_in;
   logic [PREC_W-1:0]          prec_ff, prec_in;
   logic                       short_ff, short_in;
   logic                       ext_ff, ext_in;
   logic                       alt_ff, alt_in;
   logic                       up_ff, up_in;
   logic [PREC_W-1:0]          n_ff, n_in;
   logic                       neg_ff, neg_in;
   logic [AEXP_W-1:0]          ae_ff, ae_in;
   logic [DIG_IDX_W-1:0]       ndig_ff, ndig_in;
   logic [DIG_IDX_W-1:0]       dcnt_ff, dcnt_in;
   logic [DIGITS-1:0][3:0]     dig_ff;

   logic accept;

   // Input fields
   logic [63:0] in_bits;
   logic [14:0] in_bexp;
   logic [6:0]  in_prec;

   // Decode
   logic [14:0]             ext_be;
   logic [10:0]             dbl_be;
   logic [51:0]             dbl_man;
   logic [3:0]              dec_lead;
   hfmt_frac_type           dec_frac;
   logic signed [EXP_W-1:0] dec_exp;
   logic [PREC_W-1:0]       dec_prec;

   // Rounding
   logic [3:0]         nn;
   logic               do_round;
   hfmt_frac_type      keep_frac;
   logic [3:0]         half;
   logic               rest;
   logic               prev;
   logic               rnd;
   logic [64:0]        inc;
   logic [64:0]        sum;
   logic [PREC_W-1:0]  n_strip;

   // Decimal digit step
   logic [31:0]        prod;
   logic [12:0]        quot;
   logic [AEXP_W-1:0]  rem;

   assign accept  = req_tvalid && req_tready;
   assign in_bits = req_tdata[63:0];
   assign in_bexp = req_tdata[78:64];
   assign in_prec = req_tdata[85:79];

   // Format decode of the incoming value
   always_comb begin
      ext_be  = (in_bexp == 15'd0) ? 15'd1 : in_bexp;
      dbl_be  = in_bits[62:52];
      dbl_man = in_bits[51:0];
      if (req_tuser) begin
         if (in_bexp == 15'd0 && in_bits == 64'd0) begin
            dec_lead = 4'd0;
            dec_frac = '0;
            dec_exp  = '0;
         end else begin
            dec_lead = in_bits[63:60];
            dec_frac = hfmt_frac_type'(in_bits[59:0]);
            dec_exp  = $signed({1'b0, ext_be}) - EXT_EXP_ADJ;
         end
      end else begin
         dec_frac = hfmt_frac_type'({dbl_man, 8'd0});
         if (dbl_be == 11'd0) begin
            dec_lead = 4'd0;
            dec_exp  = (dbl_man != 52'd0) ? DBL_DENORM_EXP : '0;
         end else begin
            dec_lead = 4'd1;
            dec_exp  = $signed({5'd0, dbl_be}) - DBL_BIAS;
         end
      end
      // negative precision means shortest form; large values saturate
      if (in_prec[6]) begin
         dec_prec = '0;
      end else if (in_prec[5:0] > PREC_MAX) begin
         dec_prec = PREC_MAX;
      end else begin
         dec_prec = in_prec[5:0];
      end
   end

   // Round half-to-even at the precision, and count digits for shortest form
   always_comb begin
      nn       = ext_ff ? NN_EXTENDED : NN_DOUBLE;
      do_round = !short_ff && (prec_ff < {2'b0, nn});
      half     = '0;
      rest     = 1'b0;
      prev     = lead_ff[0];
      n_strip  = '0;
      keep_frac = '0;
      for (int i = 0; i < FRAC_NIBS; i++) begin
         if (PREC_W'(i) < prec_ff) begin
            keep_frac[i] = frac_ff[i];
         end
         if (PREC_W'(i) == prec_ff) begin
            half = frac_ff[i];
         end
         if (PREC_W'(i) > prec_ff && frac_ff[i] != 4'd0) begin
            rest = 1'b1;
         end
         if (PREC_W'(i + 1) == prec_ff) begin
            prev = frac_ff[i][0];
         end
         if (frac_ff[i] != 4'd0) begin
            n_strip = PREC_W'(i + 1);
         end
      end
      rnd = (half > 4'd8) || (half == 4'd8 && (rest || prev));
      inc = 65'd1 << (8'd60 - {prec_ff, 2'b00});
      sum = {1'b0, lead_ff, keep_frac} + (rnd ? inc : 65'd0);
   end

   // One decimal digit per cycle by reciprocal multiply
   always_comb begin
      prod = {17'd0, ae_ff} * RECIP_TEN;
      quot = prod[31:RECIP_SHFT];
      rem  = ae_ff - AEXP_W'({quot, 3'b000} + {1'b0, quot, 1'b0});
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) state_in = F_ROUND;
         end
         F_ROUND: state_in = F_EXP;
         F_EXP:   state_in = F_DIG;
         F_DIG: begin
            if (dcnt_ff == DIG_IDX_W'(DIGITS - 1)) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_tready = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         F_IDLE:  req_tready = 1'b1;
         F_PUSH:  push_valid = 1'b1;
         default: begin
            req_tready = 1'b0;
            push_valid = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      lead_in  = lead_ff;
      frac_in  = frac_ff;
      exp_in   = exp_ff;
      prec_in  = prec_ff;
      short_in = short_ff;
      ext_in   = ext_ff;
      alt_in   = alt_ff;
      up_in    = up_ff;
      n_in     = n_ff;
      neg_in   = neg_ff;
      ae_in    = ae_ff;
      ndig_in  = ndig_ff;
      dcnt_in  = dcnt_ff;
      case (state_ff)
         F_IDLE: begin
            lead_in  = dec_lead;
            frac_in  = dec_frac;
            exp_in   = dec_exp;
            prec_in  = dec_prec;
            short_in = in_prec[6];
            ext_in   = req_tuser;
            alt_in   = req_tdata[86];
            up_in    = req_tdata[87];
         end
         F_ROUND: begin
            n_in = short_ff ? n_strip : prec_ff;
            if (do_round) begin
               frac_in = hfmt_frac_type'(sum[59:0]);
               if (sum[64]) begin
                  lead_in = 4'd1;
                  exp_in  = exp_ff + RENORM_STEP;
               end else begin
                  lead_in = sum[63:60];
               end
            end
         end
         F_EXP: begin
            neg_in  = exp_ff[EXP_W-1];
            ae_in   = exp_ff[EXP_W-1] ? AEXP_W'(-exp_ff) : exp_ff[AEXP_W-1:0];
            dcnt_in = '0;
            if (ae_in >= 15'd10000) begin
               ndig_in = 3'd5;
            end else if (ae_in >= 15'd1000) begin
               ndig_in = 3'd4;
            end else if (ae_in >= 15'd100) begin
               ndig_in = 3'd3;
            end else if (ae_in >= 15'd10) begin
               ndig_in = 3'd2;
            end else begin
               ndig_in = 3'd1;
            end
         end
         F_DIG: begin
            ae_in   = {2'b00, quot};
            dcnt_in = dcnt_ff + 3'd1;
         end
         default: begin
            dcnt_in = dcnt_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lead_ff  <= lead_in;
      frac_ff  <= frac_in;
      exp_ff   <= exp_in;
      prec_ff  <= prec_in;
      short_ff <= short_in;
      ext_ff   <= ext_in;
      alt_ff   <= alt_in;
      up_ff    <= up_in;
      n_ff     <= n_in;
      neg_ff   <= neg_in;
      ae_ff    <= ae_in;
      ndig_ff  <= ndig_in;
      dcnt_ff  <= dcnt_in;
      if (state_ff == F_DIG) begin
         dig_ff[dcnt_ff] <= rem[3:0];
      end
   end

   // Entry handed to the queue
   always_comb begin
      push_entry.lead   = lead_ff;
      push_entry.frac   = frac_ff;
      push_entry.n_frac = n_ff;
      push_entry.dot    = (n_ff != '0) || alt_ff;
      push_entry.upper  = up_ff;
      push_entry.neg    = neg_ff;
      push_entry.n_dig  = ndig_ff;
      push_entry.dig    = dig_ff;
   end

endmodule

// File: src/hfmt_queue.sv
// Small FIFO of formatted values between front end and character sequencer.
// Depends on hfmt_pkg.

module hfmt_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  hfmt_pkg::hfmt_entry_type push_entry,
   output logic                     pop_valid,
   input  logic                     pop,
   output hfmt_pkg::hfmt_entry_type head
);
   import hfmt_pkg::*;

   hfmt_entry_type      mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign head       = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: src/hfmt_back.sv
// Character sequencer: walks one queued value and emits its text, one
// character per transfer, through an output register. Depends on hfmt_pkg.

module hfmt_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  hfmt_pkg::hfmt_entry_type head,
   output logic                     q_pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast
);
   import hfmt_pkg::*;

   hfmt_back_state_type state_ff, state_in;

   logic [PREC_W-1:0]    fidx_ff, fidx_in;
   logic [DIG_IDX_W-1:0] didx_ff, didx_in;
   logic                 valid_ff;
   logic [7:0]           data_ff;
   logic                 last_ff;

   logic       out_free;
   logic       step;
   logic [3:0] nib;
   logic [7:0] ch;
   logic       ch_last;

   assign out_free   = !valid_ff || rsp_tready;
   assign step       = q_valid && out_free;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   // Fraction nibble, zero past the stored digits
   assign nib = (fidx_ff < PREC_W'(FRAC_NIBS)) ? head.frac[fidx_ff[3:0]] : 4'd0;

   // Next state
   always_comb begin
      state_in = state_ff;
      if (step) begin
         case (state_ff)
            B_ZERO: state_in = B_X;
            B_X:    state_in = B_LEAD;
            B_LEAD: state_in = head.dot ? B_DOT : B_PCHAR;
            B_DOT:  state_in = (head.n_frac != '0) ? B_FRAC : B_PCHAR;
            B_FRAC: begin
               if (fidx_ff + 1'b1 == head.n_frac) state_in = B_PCHAR;
            end
            B_PCHAR: state_in = B_SIGN;
            B_SIGN:  state_in = B_DIGIT;
            B_DIGIT: begin
               if (didx_ff == '0) state_in = B_ZERO;
            end
            default: state_in = B_ZERO;
         endcase
      end
   end

   // Character for the current state
   always_comb begin
      ch      = CH_ZERO;
      ch_last = 1'b0;
      q_pop   = 1'b0;
      case (state_ff)
         B_ZERO:  ch = CH_ZERO;
         B_X:     ch = head.upper ? CH_X_UP : CH_X_LO;
         B_LEAD:  ch = hex_char(head.lead, head.upper);
         B_DOT:   ch = CH_DOT;
         B_FRAC:  ch = hex_char(nib, head.upper);
         B_PCHAR: ch = head.upper ? CH_P_UP : CH_P_LO;
         B_SIGN:  ch = head.neg ? CH_MINUS : CH_PLUS;
         B_DIGIT: begin
            ch      = CH_ZERO + {4'd0, head.dig[didx_ff]};
            ch_last = (didx_ff == '0);
            q_pop   = step && (didx_ff == '0);
         end
         default: ch = CH_ZERO;
      endcase
   end

   // Digit position counters
   always_comb begin
      fidx_in = fidx_ff;
      didx_in = didx_ff;
      if (step) begin
         fidx_in = (state_ff == B_FRAC) ? fidx_ff + 1'b1 : '0;
         if (state_ff == B_SIGN) begin
            didx_in = head.n_dig - 1'b1;
         end else if (state_ff == B_DIGIT) begin
            didx_in = didx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_ZERO;
         fidx_ff  <= '0;
         didx_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fidx_ff  <= fidx_in;
         didx_ff  <= didx_in;
         if (out_free) begin
            valid_ff <= step;
         end
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         data_ff <= ch;
         last_ff <= ch_last;
      end
   end

endmodule

// File: src/hex_float_text_formatter_unit.sv
// Top level of the hex float (%a) text formatter.
// Depends on hfmt_pkg, hfmt_front, hfmt_queue and hfmt_back.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------
//  req     | in  | req_tvalid/tready   | tdata: value, exponent, precision, flags
//          |     |                     | tuser: extended
//  rsp     | out | rsp_tvalid/tready   | tdata: character; tlast: final character
//
// The front end takes a value through accept, round, exponent sign, five
// decimal digit steps of the reciprocal multiply and a queue write.
// The sequencer emits one character per cycle unless the queue is empty or
// rsp_tready stalls it, 6 to 59 characters per value.
// A two-entry queue lets the front end work on the next value while the
// sequencer is stalled by rsp_tready; the output register holds a waiting
// character. Reset is synchronous and empties the queue and both sequencers.

module hex_float_text_formatter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [63:0] value_bits, [78:64] biased_exponent, [85:79] precision,
   // [86] alt_form, [87] upper_case
   input  logic [87:0] req_tdata,
   // [0] extended
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_char
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);
   import hfmt_pkg::*;

   logic           push_valid;
   logic           push_ready;
   hfmt_entry_type push_entry;
   logic           q_valid;
   logic           q_pop;
   hfmt_entry_type q_head;

   hfmt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   hfmt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .head       (q_head)
   );

   hfmt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head       (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The front end is busy right after taking a value
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("front end ready right after an accepted transfer");

   // Every value ends on a decimal exponent digit
   a_last_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata >= CH_ZERO && rsp_tdata <= CH_NINE)
      else $error("final character is not a decimal digit");

   // The sequencer only retires a queued value that exists
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue pop while empty");

endmodule
